FILE: rtl/rse_pkg.sv
// Package for the postfix stack evaluator: sizes, character codes, status codes,
// sequencer states and the request structs of both channels.
// No dependencies.
package rse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
  localparam int MD_STEPS    = DATA_W;
  localparam int MD_CW       = $clog2(MD_STEPS);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_BADCHAR = 3'd1,
    STAT_UNDER   = 3'd2,
    STAT_OVER    = 3'd3,
    STAT_DIVZERO = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]         ch;
    logic               first;
    logic               last;
    logic signed [31:0] arg_value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_req_t;

  typedef struct packed {
    logic start;
    logic div;
  } md_cmd_t;

endpackage

FILE: rtl/rpn_stack_evaluator.sv
// Postfix integer expression evaluator, one character per request.
// Depends on rse_pkg, rse_ram and rse_muldiv.
//
// Input channel: in_valid_i / in_stall_o carry in_req_i (character, first,
// last, argument). Output channel: out_valid_o / out_stall_i carry out_req_o
// (value, status); one result follows each request marked last.
// A request is taken only while the sequencer is idle; in_stall_o is high
// while a request is in work.
// Sequencer states per request, from accept to the next accept:
//   digit, bad character, error or ignored request: decode, done
//   + and -: decode, read, done (stack read through the registered RAM port)
//   * and /: decode, read, wait for the 32 steps of the shared one-bit-per-cycle
//   multiply/divide unit with set-up in read and write-back at its end, done.
// A result sits in an output register; the next request is accepted while it
// waits. If a later last request finishes while that result is still stalled,
// the sequencer holds until the receiver takes it.
// Reset clears the top value, stack count, number flag, error code and the
// output valid; stack RAM contents are undefined until pushed.
module rpn_stack_evaluator
  import rse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_req_t  in_req_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  output out_req_t out_req_o,
  input  logic     out_stall_i
);

  state_e               state_q, state_d;
  logic [DATA_W-1:0]    top_q, top_d;
  logic [STACK_CW-1:0]  cnt_q, cnt_d;
  logic                 innum_q, innum_d;
  status_e              err_q, err_d;
  logic [7:0]           ch_q;
  logic                 last_q;
  logic                 out_valid_q, out_valid_d;
  out_req_t             out_q, out_d;

  logic                 accept;
  logic                 is_digit, is_op;
  logic [3:0]           digit;
  logic                 ram_we;
  logic [STACK_AW-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;
  md_cmd_t              md_cmd;
  logic                 md_done;
  logic [DATA_W-1:0]    md_result;
  logic                 out_free;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign is_digit   = (ch_q inside {[CH_ZERO:CH_NINE]});
  assign is_op      = (ch_q inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH});
  assign digit      = 4'(ch_q - CH_ZERO);
  assign ram_waddr  = cnt_q[STACK_AW-1:0];
  assign ram_raddr  = STACK_AW'(cnt_q - 1'b1);
  assign out_free   = !out_valid_q || !out_stall_i;

  rse_ram #(
    .Width(DATA_W),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(top_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rse_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (md_cmd),
    .a_i     (ram_rdata),
    .b_i     (top_q),
    .done_o  (md_done),
    .result_o(md_result)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (err_q == STAT_OK && !is_digit && is_op && cnt_q != '0 &&
            !(ch_q == CH_SLASH && top_q == '0)) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        if (ch_q == CH_STAR || ch_q == CH_SLASH) begin
          state_d = ST_WAIT;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WAIT: begin
        if (md_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!last_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    top_d       = top_q;
    cnt_d       = cnt_q;
    innum_d     = innum_q;
    err_d       = err_q;
    ram_we      = 1'b0;
    md_cmd      = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_req_i.first) begin
          top_d   = in_req_i.arg_value;
          cnt_d   = '0;
          innum_d = 1'b0;
          err_d   = STAT_OK;
        end
      end
      ST_DECODE: begin
        if (err_q == STAT_OK) begin
          if (is_digit) begin
            if (innum_q) begin
              top_d = (top_q << 3) + (top_q << 1) + DATA_W'(digit);
            end else if (cnt_q >= STACK_CW'(STACK_DEPTH)) begin
              err_d = STAT_OVER;
            end else begin
              ram_we  = 1'b1;
              cnt_d   = cnt_q + 1'b1;
              top_d   = DATA_W'(digit);
              innum_d = 1'b1;
            end
          end else begin
            innum_d = 1'b0;
            if (!is_op) begin
              err_d = STAT_BADCHAR;
            end else if (cnt_q == '0) begin
              err_d = STAT_UNDER;
            end else if (ch_q == CH_SLASH && top_q == '0) begin
              err_d = STAT_DIVZERO;
            end
          end
        end
      end
      ST_READ: begin
        cnt_d = cnt_q - 1'b1;
        case (ch_q)
          CH_PLUS:  top_d = ram_rdata + top_q;
          CH_MINUS: top_d = ram_rdata - top_q;
          CH_STAR: begin
            md_cmd.start = 1'b1;
            md_cmd.div   = 1'b0;
          end
          CH_SLASH: begin
            md_cmd.start = 1'b1;
            md_cmd.div   = 1'b1;
          end
          default: top_d = top_q;
        endcase
      end
      ST_WAIT: begin
        if (md_done) begin
          top_d = md_result;
        end
      end
      ST_DONE: begin
        if (last_q && out_free) begin
          innum_d      = 1'b0;
          out_valid_d  = 1'b1;
          out_d.value  = (err_q == STAT_OK) ? top_q : '0;
          out_d.status = err_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_q       <= '0;
      cnt_q       <= '0;
      innum_q     <= 1'b0;
      err_q       <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      cnt_q       <= cnt_d;
      innum_q     <= innum_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      ch_q   <= in_req_i.ch;
      last_q <= in_req_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

FILE: rtl/rse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rse_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/rse_muldiv.sv
// Iterative 32-bit multiplier (low word) and signed truncating divider,
// one bit per cycle, with separate add and subtract paths. Depends on rse_pkg.
module rse_muldiv
  import rse_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md_cmd_t           cmd_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic              done_o,
  output logic [DATA_W-1:0] result_o
);

  logic [DATA_W-1:0] hi_q, hi_d, lo_q, lo_d, opnd_q, opnd_d;
  logic              neg_q, neg_d, div_q, div_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [MD_CW-1:0]  cnt_q, cnt_d;
  logic [DATA_W:0]   rem_sh, diff;

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    opnd_d = opnd_q;
    neg_d  = neg_q;
    div_d  = div_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_sh = {hi_q, lo_q[DATA_W-1]};
    diff   = rem_sh - {1'b0, opnd_q};
    if (cmd_i.start) begin
      div_d  = cmd_i.div;
      busy_d = 1'b1;
      cnt_d  = '0;
      hi_d   = '0;
      neg_d  = a_i[DATA_W-1] ^ b_i[DATA_W-1];
      if (cmd_i.div) begin
        lo_d   = a_i[DATA_W-1] ? (~a_i + 1'b1) : a_i;
        opnd_d = b_i[DATA_W-1] ? (~b_i + 1'b1) : b_i;
      end else begin
        lo_d   = b_i;
        opnd_d = a_i;
      end
    end else if (busy_q) begin
      if (div_q) begin
        if (!diff[DATA_W]) begin
          hi_d = diff[DATA_W-1:0];
          lo_d = {lo_q[DATA_W-2:0], 1'b1};
        end else begin
          hi_d = rem_sh[DATA_W-1:0];
          lo_d = {lo_q[DATA_W-2:0], 1'b0};
        end
      end else begin
        if (lo_q[0]) begin
          hi_d = hi_q + opnd_q;
        end
        opnd_d = {opnd_q[DATA_W-2:0], 1'b0};
        lo_d   = {1'b0, lo_q[DATA_W-1:1]};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MD_CW'(MD_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    opnd_q <= opnd_d;
    neg_q  <= neg_d;
    div_q  <= div_d;
  end

  assign done_o   = done_q;
  assign result_o = div_q ? (neg_q ? (~lo_q + 1'b1) : lo_q) : hi_q;

endmodule
